@@ rtl/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timeout queue
// Field widths, operation and status codes, and the word that steps
// through the row of queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int ID_W         = 5;
  localparam int TIME_W       = 64;
  localparam int TIMEOUT_W    = 32;
  localparam int MAX_RESULTS  = 16;
  localparam int THREADS_DEF  = 16;

  localparam logic [TIMEOUT_W-1:0] WAIT_FOREVER = '1;

  // Request codes; the fourth code is unused and answered as an error
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PARAM_ERR = 2'd1,
    ST_EXPIRED   = 2'd2,
    ST_IDLE_TICK = 2'd3
  } status_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_REMOVE = 2'd1,
    CELL_POP    = 2'd2,
    CELL_INSERT = 2'd3
  } cell_op_t;

  // One queue slot
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  // Command broadcast along the row
  typedef struct packed {
    cell_op_t          op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] key;
    logic [TIME_W-1:0] count;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/dtq_cell.sv @@
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the sorted timeout queue
// Holds a thread id and its deadline; shifts toward the head on a removal
// and toward the tail on an insertion, taking words from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  dtq_pkg::cell_cmd_t  cmd,
  input  dtq_pkg::entry_t     left,
  input  wire                 left_le,
  input  dtq_pkg::entry_t     right,
  input  wire                 hit_in,
  output dtq_pkg::entry_t     ent,
  output logic                le,
  output logic                due,
  output logic                hit_out
);
  import dtq_pkg::*;

  entry_t ent_next;
  logic   hit_here;

  // Compare against the broadcast id, deadline key and tick count
  assign hit_here = ent.valid && (ent.id == cmd.id);
  assign hit_out  = hit_in | hit_here;
  assign le       = ent.valid && (ent.deadline <= cmd.key);
  assign due      = ent.valid && (ent.deadline <= cmd.count);

  // Pick the next content of the slot
  always_comb begin
    ent_next = ent;
    unique case (cmd.op)
      CELL_HOLD: begin
      end
      CELL_REMOVE: begin
        if (hit_out) begin
          ent_next = right;
        end
      end
      CELL_POP: begin
        ent_next = right;
      end
      CELL_INSERT: begin
        if (!le) begin
          if (left_le) begin
            ent_next.valid    = 1'b1;
            ent_next.id       = cmd.id;
            ent_next.deadline = cmd.key;
          end else begin
            ent_next = left;
          end
        end
      end
    endcase
  end

  // Slot register; only the occupancy flag is reset
  always_ff @(posedge clk) begin
    ent.id       <= ent_next.id;
    ent.deadline <= ent_next.deadline;
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/deadline_timeout_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_timeout_queue: timeout queue sorted by deadline
// A row of slot cells holds waiting threads in ascending deadline order,
// equal deadlines in arrival order, next to a 64-bit tick count.
//
// Input channel (in_valid/in_ready): operation, thread_id, timeout.
//   Tick advances the count and releases every due thread from the head.
//   Set enqueues a thread at count + timeout, dropping an older entry.
//   Cancel drops a thread; an absent thread is no error.
// Output channel (out_valid/out_ready): status, expired_thread,
//   queue_empty, last. A tick gives one word per released thread (at most
//   16), or one idle word; every other request gives one word.
// Sequencing: a set passes through removal and insertion before its word,
//   a cancel through removal only, a rejected request goes straight to its
//   word, and a tick releases due threads from the head one word at a
//   time. Each cell row step moves one slot by one place. One request
//   is in work at a time; in_ready is high only between requests.
// Reset empties the queue and clears the tick count; no clearing pass.
// A stalled receiver holds the output word and the queue waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timeout_queue #(
  parameter int THREADS = dtq_pkg::THREADS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [1:0]                    operation,
  input  wire  [dtq_pkg::ID_W-1:0]      thread_id,
  input  wire  [dtq_pkg::TIMEOUT_W-1:0] timeout,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [1:0]                    status,
  output logic [dtq_pkg::ID_W-1:0]      expired_thread,
  output logic                          queue_empty,
  output logic                          last
);
  import dtq_pkg::*;

  localparam int QLEN_W = $clog2(THREADS + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int SUM_W  = (QLEN_W > RES_W) ? QLEN_W + 1 : RES_W + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REMOVE = 5'b00010,
    S_INSERT = 5'b00100,
    S_DONE   = 5'b01000,
    S_DRAIN  = 5'b10000
  } state_t;

  state_t              state;
  logic [TIME_W-1:0]   tick_count;
  logic [TIME_W-1:0]   key;
  op_t                 op_q;
  logic [ID_W-1:0]     id_q;
  status_t             resp_status;
  logic [RES_W-1:0]    n_rel;
  logic [QLEN_W-1:0]   qlen;
  status_t             status_q;

  cell_cmd_t           cmd;
  entry_t              ents  [THREADS];
  entry_t              empty_ent;
  logic [THREADS-1:0]  le_v;
  logic [THREADS-1:0]  due_v;
  logic [THREADS-1:0]  valid_v;
  logic [THREADS:0]    hit_c;
  logic [THREADS:0]    due_pad;

  logic                accept;
  logic                out_free;
  logic                emit;
  logic                req_err;
  logic                head_due;
  logic                can_pop;
  logic                all_due;
  logic [SUM_W-1:0]    total;
  logic                final_empty;
  logic                pop_last;

  assign empty_ent = '{valid: 1'b0, id: '0, deadline: '0};
  assign hit_c[0]  = 1'b0;
  assign due_pad[THREADS] = 1'b0;

  // Row of queue cells, head at index 0
  for (genvar i = 0; i < THREADS; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_le;

    if (i == 0) begin : g_head
      assign left_e  = empty_ent;
      assign left_le = 1'b1;
    end else begin : g_body
      assign left_e  = ents[i-1];
      assign left_le = le_v[i-1];
    end
    if (i == THREADS - 1) begin : g_tail
      assign right_e = empty_ent;
    end else begin : g_mid
      assign right_e = ents[i+1];
    end

    dtq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .left    (left_e),
      .left_le (left_le),
      .right   (right_e),
      .hit_in  (hit_c[i]),
      .ent     (ents[i]),
      .le      (le_v[i]),
      .due     (due_v[i]),
      .hit_out (hit_c[i+1])
    );

    assign valid_v[i] = ents[i].valid;
    assign due_pad[i] = due_v[i];
  end

  // Handshake and request checks
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign emit     = ((state == S_DONE) || (state == S_DRAIN)) && out_free;
  assign req_err  = !(operation == OP_SET || operation == OP_CANCEL) ||
                    (thread_id == '0) || (int'(thread_id) > THREADS) ||
                    ((operation == OP_SET) && (timeout == WAIT_FOREVER));

  // Release bookkeeping for the current tick
  assign head_due    = due_pad[0];
  assign can_pop     = head_due && (n_rel < RES_W'(MAX_RESULTS));
  assign all_due     = &(~valid_v | due_v);
  assign total       = SUM_W'(qlen) + SUM_W'(n_rel);
  assign final_empty = all_due && (total <= SUM_W'(MAX_RESULTS));
  assign pop_last    = (n_rel == RES_W'(MAX_RESULTS - 1)) || !due_pad[1];

  // Broadcast command to the row
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.id    = id_q;
    cmd.key   = key;
    cmd.count = tick_count;
    unique case (state)
      S_REMOVE: cmd.op = CELL_REMOVE;
      S_INSERT: cmd.op = CELL_INSERT;
      S_DRAIN: begin
        if (out_free && can_pop) begin
          cmd.op = CELL_POP;
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
  end

  // Sequencer, counters and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      qlen       <= '0;
      n_rel      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == OP_TICK) begin
              tick_count <= tick_count + 1'b1;
              n_rel      <= '0;
              state      <= S_DRAIN;
            end else if (req_err) begin
              resp_status <= ST_PARAM_ERR;
              state       <= S_DONE;
            end else begin
              state <= S_REMOVE;
            end
          end
        end
        S_REMOVE: begin
          if (hit_c[THREADS]) begin
            qlen <= qlen - 1'b1;
          end
          resp_status <= ST_OK;
          state       <= (op_q == OP_SET) ? S_INSERT : S_DONE;
        end
        S_INSERT: begin
          qlen  <= qlen + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            status_q       <= resp_status;
            expired_thread <= '0;
            queue_empty    <= (qlen == '0);
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            if (can_pop) begin
              status_q       <= ST_EXPIRED;
              expired_thread <= ents[0].id;
              queue_empty    <= final_empty;
              last           <= pop_last;
              qlen           <= qlen - 1'b1;
              n_rel          <= n_rel + 1'b1;
              if (pop_last) begin
                state <= S_IDLE;
              end
            end else begin
              status_q       <= ST_IDLE_TICK;
              expired_thread <= '0;
              queue_empty    <= (qlen == '0);
              last           <= 1'b1;
              state          <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op_t'(operation);
      id_q <= thread_id;
      key  <= tick_count + TIME_W'(timeout);
    end
  end

  assign status = status_q;

  // Length counter tracks the occupied slots
  a_qlen_match: assert property (@(posedge clk) disable iff (rst)
    QLEN_W'($countones(valid_v)) == qlen)
    else $error("queue length disagrees with occupied slots");

  // Occupied slots form an unbroken run from the head
  a_packed_row: assert property (@(posedge clk) disable iff (rst)
    (valid_v & (valid_v + 1'b1)) == '0)
    else $error("gap in the slot row");

  // A tick advances the count by one
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_TICK) |=> tick_count == $past(tick_count) + 1'b1)
    else $error("tick count did not advance");

  // Releases per tick stay within the limit
  a_release_cap: assert property (@(posedge clk) disable iff (rst)
    n_rel <= RES_W'(MAX_RESULTS))
    else $error("too many releases in one tick");

endmodule

`default_nettype wire

@@ test/deadline_timeout_queue_tb.sv @@
// ----------------------------------------------------------------------------
// deadline_timeout_queue_tb: self-checking bench for the deadline timeout queue
// Walks a short table of directed requests, then random ticks, sets and
// cancels under several idle and stall mixes. This includes a long receiver
// hold-off while the sender keeps offering sets of all sixteen threads on
// one deadline. Every output word is checked against a sorted-queue
// predictor kept in the bench, or against the answer typed into the table.
// ----------------------------------------------------------------------------
module deadline_timeout_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dtq_pkg::*;

  localparam int          THREAD_COUNT = THREADS_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          PHASE_ITEMS  = 57;

  // One output word as the block should give it
  typedef struct {
    status_t         status;
    logic [ID_W-1:0] thread;
    logic            empty;
    logic            last;
  } word_t;

  // One directed request, with its answer typed in where it is obvious
  typedef struct {
    logic [1:0]           op;
    logic [ID_W-1:0]      id;
    logic [TIMEOUT_W-1:0] to;
    bit                   typed;
    word_t                answer;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           operation = OP_TICK;
  logic [ID_W-1:0]      thread_id = '0;
  logic [TIMEOUT_W-1:0] timeout = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic [ID_W-1:0]      expired_thread;
  logic                 queue_empty;
  logic                 last;

  deadline_timeout_queue dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .thread_id      (thread_id),
    .timeout        (timeout),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .expired_thread (expired_thread),
    .queue_empty    (queue_empty),
    .last           (last)
  );

  // Shadow of the queue state
  logic [TIME_W-1:0] shadow_count;
  logic [TIME_W-1:0] shadow_deadline [THREAD_COUNT];
  bit                shadow_queued   [THREAD_COUNT];
  int                shadow_order    [$];

  word_t expected_words [$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    recv_hold = 0;

  // Free-running clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Bound the run
  initial begin
    #2ms;
    $display("deadline_timeout_queue test failed");
    $finish;
  end

  // Drive out_ready: a long hold-off when asked, else random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold = recv_hold - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void drop_thread(int idx);
    if (shadow_queued[idx]) begin
      foreach (shadow_order[p]) begin
        if (shadow_order[p] == idx) begin
          shadow_order.delete(p);
          break;
        end
      end
      shadow_queued[idx] = 1'b0;
    end
  endfunction

  function automatic void enqueue_thread(int idx);
    int pos;
    pos = 0;
    while (pos < shadow_order.size() &&
           shadow_deadline[shadow_order[pos]] <= shadow_deadline[idx])
      pos++;
    shadow_order.insert(pos, idx);
    shadow_queued[idx] = 1'b1;
  endfunction

  function automatic word_t make_word(status_t st, logic [ID_W-1:0] thr, logic lst);
    word_t w;
    w.status = st;
    w.thread = thr;
    w.empty  = (shadow_order.size() == 0);
    w.last   = lst;
    return w;
  endfunction

  // Apply one accepted request to the shadow and queue the words it causes
  function automatic void predict_release(logic [1:0] op, logic [ID_W-1:0] id,
                                          logic [TIMEOUT_W-1:0] to);
    int released [$];
    int idx;
    if (op == OP_TICK) begin
      shadow_count = shadow_count + 1;
      while (shadow_order.size() > 0 && released.size() < MAX_RESULTS &&
             shadow_deadline[shadow_order[0]] <= shadow_count) begin
        idx = shadow_order[0];
        drop_thread(idx);
        released.push_back(idx);
      end
      if (released.size() == 0)
        expected_words.push_back(make_word(ST_IDLE_TICK, '0, 1'b1));
      foreach (released[k])
        expected_words.push_back(make_word(ST_EXPIRED, ID_W'(released[k] + 1),
                                           k == released.size() - 1));
    end else if (op == OP_UNUSED || id == 0 || id > THREAD_COUNT ||
                 (op == OP_SET && to == WAIT_FOREVER)) begin
      expected_words.push_back(make_word(ST_PARAM_ERR, '0, 1'b1));
    end else begin
      idx = int'(id) - 1;
      drop_thread(idx);
      if (op == OP_SET) begin
        shadow_deadline[idx] = shadow_count + TIME_W'(to);
        enqueue_thread(idx);
      end
      expected_words.push_back(make_word(ST_OK, '0, 1'b1));
    end
  endfunction

  // Offer one word, with random idle cycles ahead of it, and hold until taken
  task automatic send_word(input logic [1:0] op, input logic [ID_W-1:0] id,
                           input logic [TIMEOUT_W-1:0] to, input bit typed,
                           input word_t answer);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    operation <= op;
    thread_id <= id;
    timeout   <= to;
    do @(posedge clk); while (!in_ready);
    predict_release(op, id, to);
    // Replace the prediction by the answer typed into the table
    if (typed) begin
      void'(expected_words.pop_back());
      expected_words.push_back(answer);
    end
  endtask

  // Lower valid and hold off until every expected word has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
  endtask

  function automatic stim_row_t mk_row(logic [1:0] op, logic [ID_W-1:0] id,
                                       logic [TIMEOUT_W-1:0] to, bit typed,
                                       status_t st, logic empty);
    stim_row_t r;
    r.op            = op;
    r.id            = id;
    r.to            = to;
    r.typed         = typed;
    r.answer.status = st;
    r.answer.thread = '0;
    r.answer.empty  = empty;
    r.answer.last   = 1'b1;
    return r;
  endfunction

  // Pick a random request: mostly well-formed, some bad ids and unused codes
  task automatic send_random();
    logic [1:0]           op;
    logic [ID_W-1:0]      id;
    logic [TIMEOUT_W-1:0] to;
    int                   pick;
    word_t                none;
    pick = $urandom_range(99);
    if (pick < 40)      op = OP_TICK;
    else if (pick < 80) op = OP_SET;
    else if (pick < 95) op = OP_CANCEL;
    else                op = OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 88)      id = ID_W'($urandom_range(THREAD_COUNT, 1));
    else if (pick < 93) id = '0;
    else                id = ID_W'($urandom_range(31, THREAD_COUNT + 1));
    to = $urandom;
    if (op == OP_SET) begin
      pick = $urandom_range(99);
      if (pick < 60)      to = $urandom_range(6);
      else if (pick < 80) to = $urandom_range(40);
      else if (pick < 90) to = $urandom;
      else if (pick < 95) to = WAIT_FOREVER;
      else                to = $urandom_range(32'hFFFF_FFFE, 32'hFFFF_FFF0);
    end
    none = '{ST_OK, '0, 1'b0, 1'b0};
    send_word(op, id, to, 1'b0, none);
  endtask

  // Check every accepted output word against the oldest expectation
  always @(posedge clk) begin
    word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: status %0d thread %0d", status, expired_thread);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, status);
          errors++;
        end
        if (expired_thread !== w.thread) begin
          $error("expired_thread: expected %0d, got %0d", w.thread, expired_thread);
          errors++;
        end
        if (queue_empty !== w.empty) begin
          $error("queue_empty: expected %0d, got %0d", w.empty, queue_empty);
          errors++;
        end
        if (last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, last);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    stim_row_t directed_rows [$];
    word_t     none;
    int        mix_idle  [4];
    int        mix_stall [4];

    none = '{ST_OK, '0, 1'b0, 1'b0};
    shadow_count = '0;
    foreach (shadow_queued[i]) begin
      shadow_queued[i]   = 1'b0;
      shadow_deadline[i] = '0;
    end

    // Hold reset, then release it
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: errors and idle answers first, then ordering cases
    directed_rows.push_back(mk_row(OP_TICK,   0,  0,            1, ST_IDLE_TICK, 1));
    directed_rows.push_back(mk_row(OP_SET,    0,  5,            1, ST_PARAM_ERR, 1));
    directed_rows.push_back(mk_row(OP_CANCEL, 0,  0,            1, ST_PARAM_ERR, 1));
    directed_rows.push_back(mk_row(OP_SET,    1,  WAIT_FOREVER, 1, ST_PARAM_ERR, 1));
    directed_rows.push_back(mk_row(OP_UNUSED, 1,  3,            1, ST_PARAM_ERR, 1));
    directed_rows.push_back(mk_row(OP_SET,    17, 2,            1, ST_PARAM_ERR, 1));
    directed_rows.push_back(mk_row(OP_CANCEL, 31, WAIT_FOREVER, 1, ST_PARAM_ERR, 1));
    directed_rows.push_back(mk_row(OP_CANCEL, 5,  0,            1, ST_OK,        1));
    directed_rows.push_back(mk_row(OP_SET,    16, 0,            1, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_TICK,   0,  0,            0, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_SET,    1,  3,            0, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_SET,    2,  3,            0, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_SET,    1,  3,            0, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_SET,    3,  32'hFFFF_FFFE, 0, ST_OK,       0));
    directed_rows.push_back(mk_row(OP_SET,    4,  2,            0, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_CANCEL, 3,  0,            0, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_TICK,   0,  32'h5555_AAAA, 0, ST_OK,       0));
    directed_rows.push_back(mk_row(OP_TICK,   0,  0,            0, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_TICK,   0,  0,            0, ST_OK,        0));
    directed_rows.push_back(mk_row(OP_TICK,   0,  0,            0, ST_OK,        0));
    foreach (directed_rows[r])
      send_word(directed_rows[r].op, directed_rows[r].id, directed_rows[r].to,
                directed_rows[r].typed, directed_rows[r].answer);
    wait_drained();

    // Fill the queue on one deadline while the receiver holds off
    recv_hold = 400;
    for (int t = 1; t <= THREAD_COUNT; t++)
      send_word(OP_SET, ID_W'(t), 1, 1'b0, none);
    send_word(OP_TICK, 0, 0, 1'b0, none);
    for (int t = 1; t <= 4; t++)
      send_word(OP_SET, ID_W'(t), 2, 1'b0, none);
    send_word(OP_TICK, 0, 0, 1'b0, none);
    send_word(OP_TICK, 0, 0, 1'b0, none);
    wait_drained();

    // Random requests under each idle and stall mix
    mix_idle  = '{0, 45, 0, 18};
    mix_stall = '{0, 0, 45, 18};
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = mix_idle[m];
      recv_stall_pct = mix_stall[m];
      repeat (PHASE_ITEMS) send_random();
      wait_drained();
    end

    // Let the block settle, then report
    repeat (50) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never came", expected_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("deadline_timeout_queue test passed");
    end else begin
      $display("deadline_timeout_queue test failed");
    end
    $finish;
  end

endmodule
